### rtl/core/segment_window_index_translate_assert.svh
// assertion macros for the segment window translator
`ifndef SEGMENT_WINDOW_INDEX_TRANSLATE_ASSERT_SVH
`define SEGMENT_WINDOW_INDEX_TRANSLATE_ASSERT_SVH

`ifndef SYNTH

// property holds at every rising clock edge outside reset
`define SWIT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SWIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SWIT_ASSERT(label, clk, rst_n, prop, msg)
`define SWIT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/swit_pkg.sv
`default_nettype none

package swit_pkg;

  localparam int unsigned SEG_W  = 32;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned IDX_W  = 48;
  localparam int unsigned SUM_W  = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_BEGIN  = 2'd0,
    OP_ADD    = 2'd1,
    OP_HASH   = 2'd2,
    OP_UNHASH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNINIT  = 3'd1,
    ST_BADPOS  = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [SEG_W-1:0]  segment_id;
    logic [SIZE_W-1:0] segment_size;
    logic [IDX_W-1:0]  local_index;
    logic [IDX_W-1:0]  global_index;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [SEG_W-1:0] result_segment;
    logic [IDX_W-1:0] result_local;
    logic [IDX_W-1:0] result_global;
    logic [IDX_W-1:0] total_positions;
    logic             loopy;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/segment_window_index_translate.sv
`default_nettype none
// Segment window index translator.
// Command channel: item_i is taken at a rising edge with start high and busy low.
// Ops: begin window, add child segment, hash (segment, local -> global) and
// unhash (global -> segment, local). Each item gives exactly one result on
// res_o, marked by res_valid_o for one cycle; the receiver cannot stall it.
// Begin, add and any item rejected up front (no window open, unhash position
// out of range) return in the cycle after acceptance, and busy stays low, so
// such items can be issued back to back.
// Hash and unhash walk the stored entries with one comparator, one entry per
// cycle from a registered-read table: a matching entry moves on to the final
// add/subtract step, and an unknown segment returns after the last entry.
// Busy is high during the walk and the final add/subtract step.
// Reset closes the window: no entries, total zero, loopy clear. The table
// contents need no clearing since only entries below the count are read.
module segment_window_index_translate
  import swit_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  logic [SEG_W-1:0] ids_mem  [MAX_SEGMENTS];
  logic [IDX_W-1:0] ends_mem [MAX_SEGMENTS];

  logic [1:0]       state_q, state_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic [SEG_W-1:0] win_seg_q, win_seg_d;
  logic             init_q, init_d;
  logic             loopy_q, loopy_d;
  logic [IDX_W-1:0] total_q, total_d;
  logic             valid_q, valid_d;

  in_item_t         req_q, req_d;
  out_item_t        res_q, res_d;
  logic [IDX_W-1:0] prev_end_q, prev_end_d;
  logic [IDX_W-1:0] hit_end_q, hit_end_d;
  logic [SEG_W-1:0] hit_seg_q, hit_seg_d;
  logic [SEG_W-1:0] rd_id_q;
  logic [IDX_W-1:0] rd_end_q;

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SEG_W-1:0] wr_id;
  logic [IDX_W-1:0] wr_end;
  logic [AW-1:0]    rd_addr;
  logic [SUM_W-1:0] add_sum;
  logic [SUM_W-1:0] calc_sum;
  logic             scan_last;
  logic             scan_hit;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign add_sum = SUM_W'(total_q) + SUM_W'(item_i.segment_size);
  // base plus local: the position is legal when this stays below the entry end
  assign calc_sum  = SUM_W'(prev_end_q) + SUM_W'(req_q.local_index);
  assign scan_last = ((CW'(ptr_q) + CW'(1)) == count_q);
  assign scan_hit  = (req_q.op == OP_HASH) ? (rd_id_q == req_q.segment_id)
                                           : (req_q.global_index < rd_end_q);

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    count_d    = count_q;
    win_seg_d  = win_seg_q;
    init_d     = init_q;
    loopy_d    = loopy_q;
    total_d    = total_q;
    valid_d    = 1'b0;
    req_d      = req_q;
    prev_end_d = prev_end_q;
    hit_end_d  = hit_end_q;
    hit_seg_d  = hit_seg_q;
    wr_en      = 1'b0;
    wr_addr    = count_q[AW-1:0];
    wr_id      = item_i.segment_id;
    wr_end     = add_sum[IDX_W-1:0];
    res_d      = '0;
    res_d.status = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = item_i;
          unique case (item_i.op)
            OP_BEGIN: begin
              valid_d   = 1'b1;
              loopy_d   = 1'b0;
              init_d    = 1'b1;
              win_seg_d = item_i.segment_id;
              count_d   = CW'(1);
              total_d   = IDX_W'(item_i.segment_size);
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_end    = IDX_W'(item_i.segment_size);
            end
            OP_ADD: begin
              valid_d = 1'b1;
              if (!init_q) begin
                res_d.status = ST_UNINIT;
              end else if (item_i.segment_id == win_seg_q) begin
                loopy_d = 1'b1;
              end else if (count_q == CW'(MAX_SEGMENTS)) begin
                res_d.status = ST_FULL;
              end else if (add_sum[IDX_W]) begin
                res_d.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
                total_d = add_sum[IDX_W-1:0];
              end
            end
            OP_HASH: begin
              if (!init_q) begin
                valid_d      = 1'b1;
                res_d.status = ST_UNINIT;
              end else begin
                state_d    = S_SCAN;
                ptr_d      = '0;
                prev_end_d = '0;
              end
            end
            OP_UNHASH: begin
              if (!init_q) begin
                valid_d      = 1'b1;
                res_d.status = ST_UNINIT;
              end else if (item_i.global_index >= total_q) begin
                valid_d      = 1'b1;
                res_d.status = ST_BADPOS;
              end else begin
                state_d    = S_SCAN;
                ptr_d      = '0;
                prev_end_d = '0;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          hit_end_d = rd_end_q;
          hit_seg_d = rd_id_q;
          state_d   = S_CALC;
        end else if (scan_last) begin
          // only a hash can run off the end: unhash is range checked up front
          valid_d      = 1'b1;
          res_d.status = ST_UNKNOWN;
          state_d      = S_IDLE;
        end else begin
          prev_end_d = rd_end_q;
          ptr_d      = ptr_q + AW'(1);
        end
      end
      S_CALC: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
        if (req_q.op == OP_HASH) begin
          if (calc_sum >= SUM_W'(hit_end_q)) begin
            res_d.status = ST_BADPOS;
          end else begin
            res_d.result_global = calc_sum[IDX_W-1:0];
          end
        end else begin
          res_d.result_segment = hit_seg_q;
          res_d.result_local   = req_q.global_index - prev_end_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.total_positions = total_d;
    res_d.loopy           = loopy_d;
    rd_addr               = ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      count_q   <= '0;
      win_seg_q <= '0;
      init_q    <= 1'b0;
      loopy_q   <= 1'b0;
      total_q   <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      count_q   <= count_d;
      win_seg_q <= win_seg_d;
      init_q    <= init_d;
      loopy_q   <= loopy_d;
      total_q   <= total_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    prev_end_q <= prev_end_d;
    hit_end_q  <= hit_end_d;
    hit_seg_q  <= hit_seg_d;
  end

  // entry table, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ids_mem[wr_addr]  <= wr_id;
      ends_mem[wr_addr] <= wr_end;
    end
    rd_id_q  <= ids_mem[rd_addr];
    rd_end_q <= ends_mem[rd_addr];
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

`include "segment_window_index_translate_assert.svh"

  `SWIT_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_SEGMENTS), "entry count overran table")
  `SWIT_ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni, state_q == S_SCAN, (CW'(ptr_q) < count_q) && init_q, "scan pointer past stored entries")
  `SWIT_ASSERT_IMPL(a_result_source, clk_i, rst_ni, res_valid_o, $past(accept) || ($past(state_q) == S_SCAN) || ($past(state_q) == S_CALC), "result without a pending item")
  `SWIT_ASSERT_IMPL(a_total_closed, clk_i, rst_ni, !init_q, (total_q == '0) && (count_q == '0), "closed window holds positions")

endmodule

`default_nettype wire
